### rtl/core/bole_pkg.sv
// Shared types, codes and sizes for the bounded ordered list engine.
package bole_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned CmdW       = 4;
  localparam int unsigned PosW       = 5;
  localparam int unsigned WordW      = 32;
  localparam int unsigned StatW      = 2;
  localparam int unsigned FidxW      = 4;
  localparam int unsigned EcntW      = 5;
  localparam int unsigned CmpW       = (CntW > PosW) ? CntW : PosW;

  typedef logic [WordW-1:0] word_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [CmdW-1:0] {
    CmdPushFront   = 4'd0,
    CmdPushBack    = 4'd1,
    CmdInsertAt    = 4'd2,
    CmdRemoveFront = 4'd3,
    CmdRemoveBack  = 4'd4,
    CmdRemoveAt    = 4'd5,
    CmdGetFront    = 4'd6,
    CmdGetBack     = 4'd7,
    CmdGetAt       = 4'd8,
    CmdFind        = 4'd9,
    CmdClear       = 4'd10
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StRange = 2'd3
  } status_e;

  // Shift control broadcast to every cell.
  typedef struct packed {
    logic  ins;
    logic  rem;
    idx_t  at;
    word_t val;
  } shift_ctl_t;

  // Decode result handed from the controller to the top level.
  typedef struct packed {
    status_e status;
    logic    rd_en;
    idx_t    rd_at;
    logic    find_en;
    cnt_t    cnt_d;
  } op_info_t;

endpackage

### rtl/core/bole_cmd_if.sv
// Command channel: valid/ready handshake with the command payload.
interface bole_cmd_if import bole_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [CmdW-1:0]          command;
  logic [PosW-1:0]          position;
  logic signed [WordW-1:0]  item_value;

  modport source (output valid, command, position, item_value, input ready);
  modport sink   (input valid, command, position, item_value, output ready);

endinterface

### rtl/core/bole_res_if.sv
// Result channel: valid/ready handshake with the result payload.
interface bole_res_if import bole_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [StatW-1:0]         status;
  logic signed [WordW-1:0]  read_value;
  logic                     found;
  logic [FidxW-1:0]         found_index;
  logic [EcntW-1:0]         entry_count;
  logic                     is_empty;

  modport source (output valid, status, read_value, found, found_index, entry_count,
                  is_empty, input ready);
  modport sink   (input valid, status, read_value, found, found_index, entry_count,
                  is_empty, output ready);

endinterface

### rtl/core/bole_cell.sv
// One list cell: holds one entry, shifts with its neighbors, compares against the key.
module bole_cell import bole_pkg::*; (
  input  logic       clk_i,
  input  idx_t       idx_i,
  input  shift_ctl_t ctl_i,
  input  word_t      left_i,
  input  word_t      right_i,
  input  cnt_t       cnt_i,
  output word_t      data_o,
  output logic       match_o
);

  word_t data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (idx_i == ctl_i.at) begin
        data_d = ctl_i.val;
      end else if (idx_i > ctl_i.at) begin
        data_d = left_i;
      end
    end else if (ctl_i.rem) begin
      if (idx_i >= ctl_i.at) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  // only cells below the count hold live entries
  assign match_o = (data_q == ctl_i.val) && (CntW'(idx_i) < cnt_i);

endmodule

### rtl/core/bole_ctrl.sv
// Command decode, status checks and the entry count register.
module bole_ctrl import bole_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [CmdW-1:0] command_i,
  input  logic [PosW-1:0] position_i,
  input  word_t           value_i,
  output cnt_t            cnt_o,
  output shift_ctl_t      ctl_o,
  output op_info_t        info_o
);

  cnt_t             cnt_q;
  cmd_e             cmd;
  logic [CmpW-1:0]  pos_x, cnt_x;
  logic             full, empty;
  idx_t             at_pos, at_last, at_end;
  logic             ins, rem;
  idx_t             at;

  assign cmd     = cmd_e'(command_i);
  assign pos_x   = CmpW'(position_i);
  assign cnt_x   = CmpW'(cnt_q);
  assign full    = (cnt_q >= CntW'(MaxEntries));
  assign empty   = (cnt_q == '0);
  assign at_pos  = idx_t'(position_i);
  assign at_last = idx_t'(cnt_q - CntW'(1));
  assign at_end  = idx_t'(cnt_q);

  always_comb begin
    info_o        = '0;
    info_o.status = StOk;
    info_o.cnt_d  = cnt_q;
    ins           = 1'b0;
    rem           = 1'b0;
    at            = '0;
    case (cmd)
      CmdPushFront, CmdPushBack: begin
        if (full) begin
          info_o.status = StFull;
        end else begin
          ins          = 1'b1;
          at           = (cmd == CmdPushFront) ? '0 : at_end;
          info_o.cnt_d = cnt_q + CntW'(1);
        end
      end
      CmdInsertAt: begin
        if (pos_x > cnt_x) begin
          info_o.status = StRange;
        end else if (full) begin
          info_o.status = StFull;
        end else begin
          ins          = 1'b1;
          at           = at_pos;
          info_o.cnt_d = cnt_q + CntW'(1);
        end
      end
      CmdRemoveFront, CmdRemoveBack, CmdRemoveAt: begin
        if (empty) begin
          info_o.status = StEmpty;
        end else if (cmd == CmdRemoveAt && pos_x >= cnt_x) begin
          info_o.status = StRange;
        end else begin
          rem          = 1'b1;
          at           = (cmd == CmdRemoveFront) ? '0 :
                         (cmd == CmdRemoveBack)  ? at_last : at_pos;
          info_o.cnt_d = cnt_q - CntW'(1);
        end
      end
      CmdGetFront, CmdGetBack, CmdGetAt: begin
        if (empty) begin
          info_o.status = StEmpty;
        end else if (cmd == CmdGetAt && pos_x >= cnt_x) begin
          info_o.status = StRange;
        end else begin
          info_o.rd_en = 1'b1;
          info_o.rd_at = (cmd == CmdGetFront) ? '0 :
                         (cmd == CmdGetBack)  ? at_last : at_pos;
        end
      end
      CmdFind: begin
        info_o.find_en = 1'b1;
      end
      CmdClear: begin
        info_o.cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  // shift only on an accepted transaction
  assign ctl_o.ins = ins & accept_i;
  assign ctl_o.rem = rem & accept_i;
  assign ctl_o.at  = at;
  assign ctl_o.val = value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= info_o.cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

### rtl/core/bounded_ordered_list_engine.sv
// Bounded ordered list engine: a row of shifting cells with indexed insert, remove, read, find.
// The result of a command is registered and appears in the cycle after its transaction is accepted.
// Throughput: one command per cycle unless results stall; every shift finishes in a single step
// of the cell row, and find is a parallel compare in the cells followed by a priority encoder.
// A command is taken while the result register is empty or is being drained.
// Reset clears the entry count and the result valid; cell contents stay unreset.
module bounded_ordered_list_engine import bole_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bole_cmd_if.sink    cmd_i,
  bole_res_if.source  res_o
);

  logic       accept;
  logic       out_vld_q;
  cnt_t       cnt;
  shift_ctl_t ctl;
  op_info_t   info;

  word_t                  cell_data [MaxEntries];
  logic [MaxEntries-1:0]  match;

  logic       hit;
  idx_t       hit_idx;
  word_t      rd_word;

  logic [StatW-1:0] status_q;
  word_t            read_q;
  logic             found_q;
  logic [FidxW-1:0] fidx_q;
  logic [EcntW-1:0] ecnt_q;
  logic             empty_q;

  assign cmd_i.ready = !out_vld_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  bole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (cmd_i.command),
    .position_i (cmd_i.position),
    .value_i    (word_t'(cmd_i.item_value)),
    .cnt_o      (cnt),
    .ctl_o      (ctl),
    .info_o     (info)
  );

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    word_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == MaxEntries - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    bole_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (idx_t'(g)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .cnt_i   (cnt),
      .data_o  (cell_data[g]),
      .match_o (match[g])
    );
  end

  // lowest matching position wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = MaxEntries - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit     = 1'b1;
        hit_idx = idx_t'(k);
      end
    end
  end

  assign rd_word = cell_data[info.rd_at];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= info.status;
      read_q   <= info.rd_en ? rd_word : '0;
      found_q  <= info.find_en && hit;
      fidx_q   <= (info.find_en && hit) ? FidxW'(hit_idx) : '0;
      ecnt_q   <= EcntW'(info.cnt_d);
      empty_q  <= (info.cnt_d == '0);
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.status      = status_q;
  assign res_o.read_value  = read_q;
  assign res_o.found       = found_q;
  assign res_o.found_index = fidx_q;
  assign res_o.entry_count = ecnt_q;
  assign res_o.is_empty    = empty_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt <= CntW'(MaxEntries))
    else $error("entry count above capacity");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |-> !cmd_i.ready)
    else $error("command taken while result stalled");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_e'(cmd_i.command) == CmdClear) |=>
      (res_o.valid && res_o.entry_count == '0 && res_o.is_empty))
    else $error("clear left entries");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cnt == CntW'(MaxEntries) &&
     (cmd_e'(cmd_i.command) == CmdPushFront || cmd_e'(cmd_i.command) == CmdPushBack))
      |=> (res_o.status == StFull && $stable(cnt)))
    else $error("push into full list not refused");

endmodule

### tb/bounded_ordered_list_engine_test.sv
// Testbench for the bounded ordered list engine: directed and random commands, checked in order.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_test import bole_pkg::*;;

  localparam logic [CmdW-1:0] CmdUnusedLow  = 4'd11;
  localparam logic [CmdW-1:0] CmdUnusedHigh = 4'd15;
  localparam int unsigned     LongHoldCycles = 120;

  typedef struct {
    status_e          status;
    logic [WordW-1:0] read_value;
    logic             found;
    logic [FidxW-1:0] found_index;
    logic [EcntW-1:0] entry_count;
    logic             is_empty;
  } list_result_t;

  // Shadow copy of the list; predicts the answer to each accepted command.
  class list_tracker;
    logic [WordW-1:0] entries [MaxEntries];
    int               count;
    list_result_t     expected_results [$];
    int unsigned      mismatches;
    int unsigned      results_checked;

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_command(logic [CmdW-1:0] command, logic [PosW-1:0] position,
                               logic [WordW-1:0] key);
      list_result_t r;
      int           at;
      int           i;
      r.status      = StOk;
      r.read_value  = '0;
      r.found       = 1'b0;
      r.found_index = '0;
      case (command)
        CmdPushFront, CmdPushBack, CmdInsertAt: begin
          at = (command == CmdPushFront) ? 0 : (command == CmdPushBack) ? count : int'(position);
          if (command == CmdInsertAt && int'(position) > count) begin
            r.status = StRange;
          end else if (count >= MaxEntries) begin
            r.status = StFull;
          end else begin
            for (i = count; i > at; i--) entries[i] = entries[i - 1];
            entries[at] = key;
            count++;
          end
        end
        CmdRemoveFront, CmdRemoveBack, CmdRemoveAt: begin
          at = (command == CmdRemoveFront) ? 0 :
               (command == CmdRemoveBack) ? count - 1 : int'(position);
          if (count == 0) begin
            r.status = StEmpty;
          end else if (at >= count) begin
            r.status = StRange;
          end else begin
            for (i = at; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
          end
        end
        CmdGetFront, CmdGetBack, CmdGetAt: begin
          at = (command == CmdGetFront) ? 0 :
               (command == CmdGetBack) ? count - 1 : int'(position);
          if (count == 0) r.status = StEmpty;
          else if (at >= count) r.status = StRange;
          else r.read_value = entries[at];
        end
        CmdFind: begin
          for (i = 0; i < count; i++) begin
            if (entries[i] == key) begin
              r.found       = 1'b1;
              r.found_index = FidxW'(i);
              break;
            end
          end
        end
        CmdClear: count = 0;
        default: ;
      endcase
      r.entry_count = EcntW'(count);
      r.is_empty    = (count == 0);
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
      mismatches++;
      $display("mismatch at result %0d: %s got %h expected %h", results_checked, what, got,
               want);
    endtask

    task check_result(logic [StatW-1:0] status, logic [WordW-1:0] read_value, logic found,
                      logic [FidxW-1:0] found_index, logic [EcntW-1:0] entry_count,
                      logic is_empty);
      list_result_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no command pending", status, '0);
        return;
      end
      want = expected_results.pop_front();
      if (status !== want.status) report_mismatch("status", status, want.status);
      if (read_value !== want.read_value) report_mismatch("read_value", read_value,
                                                          want.read_value);
      if (found !== want.found) report_mismatch("found", found, want.found);
      if (found_index !== want.found_index) report_mismatch("found_index", found_index,
                                                            want.found_index);
      if (entry_count !== want.entry_count) report_mismatch("entry_count", entry_count,
                                                            want.entry_count);
      if (is_empty !== want.is_empty) report_mismatch("is_empty", is_empty, want.is_empty);
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bole_cmd_if cmd_if ();
  bole_res_if res_if ();

  bounded_ordered_list_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  list_tracker tracker;
  bit          idling_on    = 1'b1;
  bit          hold_request = 1'b0;
  bit          growing      = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LongHoldCycles;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      tracker.check_result(res_if.status, res_if.read_value, res_if.found, res_if.found_index,
                           res_if.entry_count, res_if.is_empty);
  end

  task automatic send_command(input logic [CmdW-1:0] c, input logic [PosW-1:0] p,
                              input logic [WordW-1:0] v);
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= c;
    cmd_if.position   <= p;
    cmd_if.item_value <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    tracker.note_command(c, p, v);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned n_items);
    logic [CmdW-1:0]  c;
    logic [PosW-1:0]  p;
    logic [WordW-1:0] v;
    int unsigned      dice;
    int unsigned      add_weight;
    repeat (n_items) begin
      // Swing between filling up and draining so both full and empty get hit.
      if (tracker.count == MaxEntries && $urandom_range(0, 3) == 0) growing = 1'b0;
      else if (tracker.count == 0) growing = 1'b1;
      add_weight = growing ? 45 : 15;
      dice = $urandom_range(0, 99);
      if (dice < add_weight) c = CmdW'($urandom_range(CmdPushFront, CmdInsertAt));
      else if (dice < 60) c = CmdW'($urandom_range(CmdRemoveFront, CmdRemoveAt));
      else if (dice < 93) c = CmdW'($urandom_range(CmdGetFront, CmdFind));
      else if (dice < 95) c = CmdClear;
      else c = CmdW'($urandom_range(CmdUnusedLow, CmdUnusedHigh));
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: v = WordW'($urandom_range(0, 7));
        2: begin
          case ($urandom_range(0, 2))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            default: v = 32'hffff_ffff;
          endcase
        end
        default: begin
          // Reuse a stored value so find hits often.
          if (tracker.count > 0) v = tracker.entries[$urandom_range(0, tracker.count - 1)];
          else v = $urandom();
        end
      endcase
      if ($urandom_range(0, 4) == 0) p = PosW'($urandom());
      else p = PosW'($urandom_range(0, tracker.count + 1));
      send_command(c, p, v);
    end
  endtask

  initial begin
    tracker = new();
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CmdClear;
    cmd_if.position   <= '0;
    cmd_if.item_value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: reads and removals answer empty, find misses.
    send_command(CmdGetFront,    5'd0,  32'h0);
    send_command(CmdRemoveBack,  5'd0,  32'h0);
    send_command(CmdRemoveAt,    5'd0,  32'h0);
    send_command(CmdGetAt,       5'd0,  32'h0);
    send_command(CmdFind,        5'd0,  32'h0);
    send_command(CmdInsertAt,    5'd1,  32'h1234_5678);
    send_command(CmdInsertAt,    5'd0,  32'h8000_0000);
    send_command(CmdPushFront,   5'd31, 32'h7fff_ffff);
    send_command(CmdPushBack,    5'd0,  32'hffff_ffff);
    send_command(CmdInsertAt,    5'd3,  32'h0);
    send_command(CmdGetFront,    5'd0,  32'h0);
    send_command(CmdGetBack,     5'd0,  32'h0);
    send_command(CmdGetAt,       5'd2,  32'h0);
    send_command(CmdGetAt,       5'd4,  32'h0);
    send_command(CmdGetAt,       5'd31, 32'h0);
    send_command(CmdFind,        5'd0,  32'hffff_ffff);
    send_command(CmdFind,        5'd0,  32'h0000_3039);
    send_command(CmdRemoveAt,    5'd31, 32'h0);
    send_command(CmdUnusedLow,   5'd31, 32'hffff_ffff);
    send_command(CmdUnusedHigh,  5'd16, 32'h5555_5555);
    send_command(CmdRemoveFront, 5'd0,  32'h0);
    send_command(CmdRemoveAt,    5'd1,  32'h0);
    send_command(CmdClear,       5'd0,  32'h0);
    // One-entry list still checks the remove position.
    send_command(CmdPushBack,    5'd0,  32'h0000_0005);
    send_command(CmdRemoveAt,    5'd1,  32'h0);
    send_command(CmdRemoveAt,    5'd0,  32'h0);

    run_random(100);
    // Block the result side while commands keep coming, so the input backs up.
    hold_request = 1'b1;
    run_random(40);
    run_random(110);
    wait_for_results();
    run_random(150);
    idling_on = 1'b0;
    run_random(125);

    wait_for_results();
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", tracker.pending());
    $display("status: fail");
    $finish;
  end

endmodule
